// File: rtl/bsed_pkg.sv
// Package with the types and constants of the backslash escape decoder.
package bsed_pkg;

  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] CharNewline   = 8'h0A;
  localparam logic [7:0] CharEscape    = 8'h1B;
  localparam logic [7:0] CharBell      = 8'h07;
  localparam logic [7:0] CharBackspace = 8'h08;
  localparam logic [7:0] CharFormFeed  = 8'h0C;
  localparam logic [7:0] CharReturn    = 8'h0D;
  localparam logic [7:0] CharTab       = 8'h09;
  localparam logic [7:0] CharVertTab   = 8'h0B;

  localparam logic [1:0] OctDigitsMax = 2'd3;
  localparam logic [1:0] HexDigitsMax = 2'd2;

  localparam int unsigned MaxResults = 3;

  typedef enum logic [2:0] {
    MODE_TEXT = 3'd0,
    MODE_ESC  = 3'd1,
    MODE_OCT  = 3'd2,
    MODE_HEX  = 3'd3,
    MODE_HALT = 3'd4
  } mode_e;

  typedef enum logic {
    REG_ESCAPES_ENABLED  = 1'b0,
    REG_SUPPRESS_NEWLINE = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       arg_end;
    logic       final_arg;
  } bsed_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } bsed_out_t;

  typedef struct packed {
    mode_e      mode;
    logic [8:0] accum;
    logic [1:0] count;
  } dec_state_t;

  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [1:0]                 num;
  } dec_result_t;

endpackage

// File: rtl/bsed_stream_if.sv
// Valid/ready stream interface that carries one word of a given payload type.
interface bsed_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/backslash_escape_decoder_unit.sv
// Top level of the backslash escape decoder with stream channels and an APB register port.
// The first output byte of a word is presented in the cycle after the word is accepted.
// Throughput: one input word per cycle while each word yields at most one byte and out_o is
// ready; a longer word holds the input while the result register drains one byte a cycle.
// Reset: rst_ni clears the decode state, the result count and read index, and both configuration bits.
module backslash_escape_decoder_unit import bsed_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  bsed_stream_if.sink            in_i,
  bsed_stream_if.source          out_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic escapes_enabled_q, escapes_enabled_d;
  logic suppress_newline_q, suppress_newline_d;

  dec_state_t  state_q, state_d;
  dec_result_t result;
  logic [MaxResults-1:0][7:0] bytes_q, bytes_d;
  logic [1:0] num_q, num_d;
  logic [1:0] rd_q, rd_d;

  logic in_fire;
  logic out_fire;
  logic out_valid;
  logic out_last;
  reg_idx_e reg_idx;

  bsed_decode u_decode (
    .word_i             (in_i.data),
    .escapes_enabled_i  (escapes_enabled_q),
    .suppress_newline_i (suppress_newline_q),
    .state_i            (state_q),
    .state_o            (state_d),
    .result_o           (result)
  );

  assign out_valid = (rd_q != num_q);
  assign out_last  = ((rd_q + 2'd1) == num_q);
  assign out_fire  = out_valid && out_o.ready;

  assign in_i.ready = !out_valid || (out_fire && out_last);
  assign in_fire    = in_i.valid && in_i.ready;

  assign out_o.valid         = out_valid;
  assign out_o.data.out_byte = bytes_q[rd_q];
  assign out_o.data.run_last = out_last;

  always_comb begin
    bytes_d = bytes_q;
    num_d   = num_q;
    rd_d    = rd_q;
    if (in_fire) begin
      bytes_d = result.bytes;
      num_d   = result.num;
      rd_d    = 2'd0;
    end else if (out_fire) begin
      rd_d = rd_q + 2'd1;
    end
  end

  // Register port.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    escapes_enabled_d  = escapes_enabled_q;
    suppress_newline_d = suppress_newline_q;
    if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_ESCAPES_ENABLED:  escapes_enabled_d  = pwdata[0];
        REG_SUPPRESS_NEWLINE: suppress_newline_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ESCAPES_ENABLED:  prdata = {31'd0, escapes_enabled_q};
      REG_SUPPRESS_NEWLINE: prdata = {31'd0, suppress_newline_q};
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escapes_enabled_q  <= 1'b0;
      suppress_newline_q <= 1'b0;
      state_q.mode       <= MODE_TEXT;
      state_q.accum      <= 9'd0;
      state_q.count      <= 2'd0;
      num_q              <= 2'd0;
      rd_q               <= 2'd0;
    end else begin
      escapes_enabled_q  <= escapes_enabled_d;
      suppress_newline_q <= suppress_newline_d;
      if (in_fire) begin
        state_q <= state_d;
      end
      num_q <= num_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

endmodule

// File: rtl/bsed_decode.sv
// Combinational decode of one input word into next state and up to three output bytes.
module bsed_decode import bsed_pkg::*; (
  input  bsed_in_t    word_i,
  input  logic        escapes_enabled_i,
  input  logic        suppress_newline_i,
  input  dec_state_t  state_i,
  output dec_state_t  state_o,
  output dec_result_t result_o
);

  logic [7:0] b;
  logic       oct_digit;
  logic       hex_digit;
  logic [3:0] hex_val;

  assign b = word_i.data_byte;
  assign oct_digit = (b >= 8'h30) && (b <= 8'h37);

  always_comb begin
    hex_digit = 1'b1;
    hex_val   = 4'd0;
    if ((b >= 8'h30) && (b <= 8'h39)) begin
      hex_val = b[3:0];
    end else if (((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46))) begin
      hex_val = b[3:0] + 4'd9;
    end else begin
      hex_digit = 1'b0;
    end
  end

  always_comb begin
    dec_state_t  st;
    dec_result_t res;
    logic        take_text;
    st        = state_i;
    res.bytes = '0;
    res.num   = 2'd0;
    take_text = 1'b0;

    if (word_i.byte_present) begin
      case (st.mode)
        MODE_ESC: begin
          st.mode  = MODE_TEXT;
          st.accum = 9'd0;
          st.count = 2'd0;
          case (b)
            8'h61: begin res.bytes[res.num] = CharBell;      res.num = res.num + 2'd1; end
            8'h62: begin res.bytes[res.num] = CharBackspace; res.num = res.num + 2'd1; end
            8'h63: st.mode = MODE_HALT;
            8'h65: begin res.bytes[res.num] = CharEscape;    res.num = res.num + 2'd1; end
            8'h66: begin res.bytes[res.num] = CharFormFeed;  res.num = res.num + 2'd1; end
            8'h6E: begin res.bytes[res.num] = CharNewline;   res.num = res.num + 2'd1; end
            8'h72: begin res.bytes[res.num] = CharReturn;    res.num = res.num + 2'd1; end
            8'h74: begin res.bytes[res.num] = CharTab;       res.num = res.num + 2'd1; end
            8'h76: begin res.bytes[res.num] = CharVertTab;   res.num = res.num + 2'd1; end
            CharBackslash: begin
              res.bytes[res.num] = CharBackslash;
              res.num = res.num + 2'd1;
            end
            8'h30: st.mode = MODE_OCT;
            8'h78: st.mode = MODE_HEX;
            default: begin
              res.bytes[res.num] = CharBackslash;
              res.num = res.num + 2'd1;
              res.bytes[res.num] = b;
              res.num = res.num + 2'd1;
            end
          endcase
        end
        MODE_OCT, MODE_HEX: begin
          if ((st.mode == MODE_OCT) ? oct_digit : hex_digit) begin
            if (st.mode == MODE_OCT) begin
              st.accum = {st.accum[5:0], b[2:0]};
            end else begin
              st.accum = {st.accum[4:0], hex_val};
            end
            st.count = st.count + 2'd1;
            if (st.count >= ((st.mode == MODE_OCT) ? OctDigitsMax : HexDigitsMax)) begin
              res.bytes[res.num] = st.accum[7:0];
              res.num  = res.num + 2'd1;
              st.accum = 9'd0;
              st.count = 2'd0;
              st.mode  = MODE_TEXT;
            end
          end else begin
            res.bytes[res.num] = st.accum[7:0];
            res.num   = res.num + 2'd1;
            st.accum  = 9'd0;
            st.count  = 2'd0;
            st.mode   = MODE_TEXT;
            take_text = 1'b1;
          end
        end
        MODE_HALT: begin
          st.mode = MODE_HALT;
        end
        default: begin
          st.mode   = MODE_TEXT;
          take_text = 1'b1;
        end
      endcase

      if (take_text) begin
        if ((b == CharBackslash) && escapes_enabled_i) begin
          st.mode = MODE_ESC;
        end else begin
          res.bytes[res.num] = b;
          res.num = res.num + 2'd1;
        end
      end
    end

    if (word_i.arg_end) begin
      if (st.mode == MODE_HALT) begin
        if (word_i.final_arg) begin
          st.mode = MODE_TEXT;
        end
      end else begin
        if (st.mode == MODE_ESC) begin
          res.bytes[res.num] = CharBackslash;
          res.num = res.num + 2'd1;
        end else if ((st.mode == MODE_OCT) || (st.mode == MODE_HEX)) begin
          res.bytes[res.num] = st.accum[7:0];
          res.num = res.num + 2'd1;
        end
        st.mode  = MODE_TEXT;
        st.accum = 9'd0;
        st.count = 2'd0;
        if (!word_i.final_arg) begin
          res.bytes[res.num] = CharSpace;
          res.num = res.num + 2'd1;
        end else if (!suppress_newline_i) begin
          res.bytes[res.num] = CharNewline;
          res.num = res.num + 2'd1;
        end
      end
    end

    state_o  = st;
    result_o = res;
  end

endmodule
